### sv/mbrx_pkg.sv
// Shared types and constants of the Modbus RTU frame receiver.
package mbrx_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned STATUS_W = 3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_BYTE_TAKEN = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD_FRAME = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_ERROR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TICK       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd4;

    // Modbus CRC-16, reflected form.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_SIZE = 1'b0;
    localparam t_cfg_idx CFG_TIMEOUT    = 1'b1;

    // Control from the sequencer to the serial CRC unit.
    typedef struct packed {
        logic              start;
        logic              restart;
        logic [BYTE_W-1:0] data;
    } t_crc_ctl;

    // Status from the serial CRC unit.
    typedef struct packed {
        logic done;
        logic zero;
    } t_crc_sts;

endpackage

### sv/mbrx_in_if.sv
// Input channel: received bytes and idle ticks.
interface mbrx_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source(output valid, output req_type, output rx_byte, input ready);
    modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

### sv/mbrx_out_if.sv
// Result channel of the frame receiver.
interface mbrx_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] out_byte;
    logic [3:0] byte_index;
    logic       last;
    logic [3:0] rx_len;
    logic [8:0] tick_count;

    modport source(output valid, output status, output out_byte, output byte_index,
                   output last, output rx_len, output tick_count, input ready);
    modport sink(input valid, input status, input out_byte, input byte_index,
                 input last, input rx_len, input tick_count, output ready);
endinterface

### sv/modbus_rtu_frame_receiver_core.sv
// Modbus RTU frame receiver: a byte is stored and checked with a bit-serial CRC-16;
// a good frame is replayed from the buffer one word per byte, and idle ticks time out
// partial frames. Input is taken only in the idle state, so items are handled one at a
// time. A tick goes to the response state, which loads its result register before
// the next word can be taken. A byte passes acceptance, the bit-serial CRC unit (one
// bit a cycle), a register for its completion and the response state that loads the
// result register. The byte that ends a good frame instead goes through a read state
// and a write state per frame byte, set by the registered read of the frame buffer.
// A result word that waits for ready holds the block in its state. Results wait in an
// output register; no buffer clearing is needed.
module modbus_rtu_frame_receiver_core #(
    parameter int unsigned RX_BUF_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mbrx_in_if.sink            i_rx,
    mbrx_out_if.source         o_res,
    input  logic               i_cfg_we,
    input  mbrx_pkg::t_cfg_idx i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import mbrx_pkg::*;

    localparam int unsigned AW = (RX_BUF_DEPTH > 1) ? $clog2(RX_BUF_DEPTH) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(RX_BUF_DEPTH - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CRC     = 3'd1;
    localparam logic [2:0] S_RESP    = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_WR = 3'd4;

    logic [2:0]          r_state;
    logic [3:0]          r_frame_size;
    logic [7:0]          r_timeout;
    logic [3:0]          r_byte_count;
    logic [8:0]          r_idle;
    logic [3:0]          r_held;
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       r_rd_ptr;
    logic [3:0]          r_emit_idx;
    logic [STATUS_W-1:0] r_pend;
    logic                r_out_valid;

    logic [STATUS_W-1:0] r_out_status;
    logic [7:0]          r_out_byte;
    logic [3:0]          r_out_index;
    logic                r_out_last;
    logic [3:0]          r_out_len;
    logic [8:0]          r_out_ticks;

    logic [BYTE_W-1:0]   r_mem [RX_BUF_DEPTH];
    logic [BYTE_W-1:0]   r_mem_q;

    t_crc_ctl crc_ctl;
    t_crc_sts crc_sts;

    logic in_acc;
    logic byte_acc;
    logic tick_acc;
    logic tick_expired;
    logic frame_done;
    logic out_free;
    logic out_load;
    logic emit_last;

    assign i_rx.ready   = (r_state == S_IDLE);
    assign in_acc       = i_rx.valid && i_rx.ready;
    assign byte_acc     = in_acc && !i_rx.req_type;
    assign tick_acc     = in_acc && i_rx.req_type;
    assign tick_expired = (r_idle > {1'b0, r_timeout});
    assign frame_done   = (r_byte_count >= r_frame_size);
    assign out_free     = !r_out_valid || o_res.ready;
    assign out_load     = ((r_state == S_RESP) || (r_state == S_EMIT_WR)) && out_free;
    assign emit_last    = ((r_emit_idx + 4'd1) == r_held);

    assign crc_ctl.start   = byte_acc;
    assign crc_ctl.data    = i_rx.rx_byte;
    assign crc_ctl.restart = (tick_acc && tick_expired)
                          || ((r_state == S_CRC) && crc_sts.done && frame_done);

    mbrx_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_sts   (crc_sts)
    );

    // Frame buffer with registered read.
    always_ff @(posedge i_clk) begin
        if (byte_acc) begin
            r_mem[r_wr_ptr] <= i_rx.rx_byte;
        end
        r_mem_q <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_frame_size <= 4'd8;
            r_timeout    <= 8'd10;
            r_byte_count <= 4'd0;
            r_idle       <= 9'd0;
            r_held       <= 4'd0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_emit_idx   <= 4'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_SIZE: r_frame_size <= i_cfg_data[3:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                    default:        ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (tick_acc) begin
                        if (tick_expired) begin
                            r_byte_count <= 4'd0;
                            r_wr_ptr     <= '0;
                            r_held       <= 4'd0;
                            r_pend       <= ST_TIMEOUT;
                        end else begin
                            r_idle <= r_idle + 9'd1;
                            r_pend <= ST_TICK;
                        end
                        r_state <= S_RESP;
                    end else if (byte_acc) begin
                        r_idle       <= 9'd0;
                        r_held       <= 4'd0;
                        r_byte_count <= r_byte_count + 4'd1;
                        r_wr_ptr     <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + AW'(1);
                        r_state      <= S_CRC;
                    end
                end
                S_CRC: begin
                    if (crc_sts.done) begin
                        if (frame_done) begin
                            r_byte_count <= 4'd0;
                            r_wr_ptr     <= '0;
                            if (crc_sts.zero) begin
                                r_held     <= r_byte_count;
                                r_rd_ptr   <= '0;
                                r_emit_idx <= 4'd0;
                                r_state    <= S_EMIT_RD;
                            end else begin
                                r_pend  <= ST_CRC_ERROR;
                                r_state <= S_RESP;
                            end
                        end else begin
                            r_pend  <= ST_BYTE_TAKEN;
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_emit_idx <= r_emit_idx + 4'd1;
                            r_rd_ptr   <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + AW'(1);
                            r_state    <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && out_free) begin
            r_out_status <= r_pend;
            r_out_byte   <= 8'd0;
            r_out_index  <= 4'd0;
            r_out_last   <= 1'b1;
            r_out_len    <= r_held;
            r_out_ticks  <= r_idle;
        end else if ((r_state == S_EMIT_WR) && out_free) begin
            r_out_status <= ST_GOOD_FRAME;
            r_out_byte   <= r_mem_q;
            r_out_index  <= r_emit_idx;
            r_out_last   <= emit_last;
            r_out_len    <= r_held;
            r_out_ticks  <= r_idle;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.out_byte   = r_out_byte;
    assign o_res.byte_index = r_out_index;
    assign o_res.last       = r_out_last;
    assign o_res.rx_len     = r_out_len;
    assign o_res.tick_count = r_out_ticks;

    // A held frame length only survives while no partial frame is being collected.
    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count != 4'd0) |-> (r_held == 4'd0))
        else $error("held length nonzero during a partial frame");

    a_good_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_GOOD_FRAME)) |-> (o_res.byte_index < o_res.rx_len))
        else $error("good frame word index beyond frame length");

    a_good_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_GOOD_FRAME) && o_res.last)
        |-> ((o_res.byte_index + 4'd1) == o_res.rx_len))
        else $error("last flag on a word that does not end the frame");

    a_crc_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_sts.done |-> (r_state == S_CRC))
        else $error("CRC completion outside the CRC state");

    a_idle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idle <= 9'd256))
        else $error("idle tick count overflow");

endmodule

### sv/mbrx_crc_serial.sv
// Bit-serial Modbus CRC-16 unit that folds in one byte a bit at a time.
module mbrx_crc_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbrx_pkg::t_crc_ctl i_ctl,
    output mbrx_pkg::t_crc_sts o_sts
);
    import mbrx_pkg::*;

    logic [CRC_W-1:0] r_crc;
    logic [2:0]       r_bit_cnt;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_INIT;
            r_bit_cnt <= 3'd0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= !i_ctl.start && r_busy && (r_bit_cnt == 3'd7);
            if (i_ctl.start) begin
                r_crc     <= r_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_ctl.data};
                r_bit_cnt <= 3'd0;
                r_busy    <= 1'b1;
            end else if (r_busy) begin
                if (r_crc[0]) begin
                    r_crc <= (r_crc >> 1) ^ CRC_POLY;
                end else begin
                    r_crc <= r_crc >> 1;
                end
                r_bit_cnt <= r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end else if (i_ctl.restart) begin
                r_crc <= CRC_INIT;
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.zero = (r_crc == '0);

endmodule
